@@ rtl/core/ffc_pkg.sv @@
`default_nettype none

package ffc_pkg;

   localparam int FORCE_BITS_DEFAULT = 24;

   localparam int GAIN_BITS  = 16;
   localparam int Q_SHIFT    = 16;
   localparam int ROUND_HALF = 1 << (Q_SHIFT - 1);

   localparam logic [GAIN_BITS-1:0] FORCE_GAIN_RESET   = 16'd16384;
   localparam logic [GAIN_BITS-1:0] FILTER_ALPHA_RESET = 16'd655;
   localparam int                   MAX_FORCE_RESET    = 20480;

   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FORCE_GAIN    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_ALPHA  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_FORCE     = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTERNAL_MODE = 4'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE_MUL,
      ST_SCALE_RND,
      ST_FILT_MUL,
      ST_FILT_ADD,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_LIM_MUL,
      ST_CMP,
      ST_SQRT,
      ST_DIV_MUL,
      ST_DIV_LOAD,
      ST_DIV_ITER,
      ST_DONE
   } ffc_state_type;

endpackage

`default_nettype wire

@@ rtl/core/force_feedback_conditioner.sv @@
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+------------------------
// request  | req_valid req_ready req_ext_force_x/y/z        | valid & ready
//          | req_near_switch                               |
// response | rsp_valid rsp_ready rsp_device_force_x/y/z     | valid & ready
// csr      | csr_write_en csr_index csr_wdata              | write_en, no wait
//
// The time from one accept to the next is longest when the magnitude limit acts,
// shorter when it does not and shortest with near_switch set; the shared multiplier
// and the one-bit-per-cycle square root and divide set these times.
// The first item after reset skips the filter steps. In external source mode an item
// is taken and dropped.
// Reset is synchronous; it clears the filter, the registers and the response valid.
// A stalled response holds the next item in its last cycle until the output frees.
`default_nettype none

module force_feedback_conditioner
   import ffc_pkg::*;
#(
   parameter int FORCE_BITS = FORCE_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  signed [FORCE_BITS-1:0] req_ext_force_x,
   input  wire  signed [FORCE_BITS-1:0] req_ext_force_y,
   input  wire  signed [FORCE_BITS-1:0] req_ext_force_z,
   input  wire                          req_near_switch,

   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [FORCE_BITS-1:0] rsp_device_force_x,
   output logic signed [FORCE_BITS-1:0] rsp_device_force_y,
   output logic signed [FORCE_BITS-1:0] rsp_device_force_z,

   input  wire                          csr_write_en,
   input  wire  [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [((FORCE_BITS-1 > GAIN_BITS) ? FORCE_BITS-1 : GAIN_BITS)-1:0] csr_wdata
);

   localparam int FB       = FORCE_BITS;
   localparam int MW       = FB + 1;
   localparam int PW       = 2 * MW;
   localparam int CNT_BITS = $clog2(FB);

   ffc_state_type state_ff, state_in;

   logic [GAIN_BITS-1:0] gain_ff;
   logic [GAIN_BITS-1:0] alpha_ff;
   logic [FB-2:0]        maxf_ff;
   logic                 ext_ff;

   logic signed [FB-1:0] src_ff  [3];
   logic signed [FB-1:0] vec_ff  [3];
   logic signed [FB-1:0] vec_in  [3];
   logic signed [FB-1:0] filt_ff [3];
   logic signed [FB-1:0] filt_in [3];
   logic                 near_ff, near_in;
   logic                 primed_ff, primed_in;
   logic [1:0]           idx_ff, idx_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [2*FB-1:0]      m2_ff, m2_in;
   logic [FB-1:0]        root_ff, root_in;
   logic [FB:0]          rem_ff, rem_in;
   logic [FB-2:0]        dvd_ff, dvd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [FB-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [FB-1:0] rsp_x_in, rsp_y_in, rsp_z_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_prod;
   logic signed [PW-1:0] rnd;
   logic signed [FB-1:0] rnd_q;
   logic signed [MW-1:0] vec_ext;

   logic [FB+2:0]        sqrt_sh, sqrt_trial, sqrt_diff;
   logic                 sqrt_ge;
   logic [FB:0]          div_sh, div_diff;
   logic                 div_ge;
   logic [FB-2:0]        q_next;

   logic                 accept, last_idx, sqrt_last, div_last, rsp_free, over_limit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = (idx_ff == 2'd2);
   assign sqrt_last = (cnt_ff == CNT_BITS'(FB - 1));
   assign div_last  = (cnt_ff == CNT_BITS'(FB - 2));

   assign vec_ext = {vec_ff[idx_ff][FB-1], vec_ff[idx_ff]};

   always_comb begin
      mul_a = vec_ext;
      mul_b = vec_ext;
      case (state_ff)
         ST_SCALE_MUL: begin
            mul_a = {src_ff[idx_ff][FB-1], src_ff[idx_ff]};
            mul_b = $signed({{(MW-GAIN_BITS){1'b0}}, gain_ff});
         end
         ST_FILT_MUL: begin
            mul_a = vec_ext - {filt_ff[idx_ff][FB-1], filt_ff[idx_ff]};
            mul_b = $signed({{(MW-GAIN_BITS){1'b0}}, alpha_ff});
         end
         ST_LIM_MUL: begin
            mul_a = $signed({2'b00, maxf_ff});
            mul_b = $signed({2'b00, maxf_ff});
         end
         ST_DIV_MUL: begin
            mul_a = vec_ext[MW-1] ? -vec_ext : vec_ext;
            mul_b = $signed({2'b00, maxf_ff});
         end
         default: begin
            mul_a = vec_ext;
            mul_b = vec_ext;
         end
      endcase
   end

   assign mul_prod = PW'(mul_a) * PW'(mul_b);

   assign rnd   = (prod_ff + PW'(ROUND_HALF)) >>> Q_SHIFT;
   assign rnd_q = rnd[FB-1:0];

   assign over_limit = (m2_ff > prod_ff[2*FB-1:0]);

   assign sqrt_sh    = {2'b00, rem_ff[FB-2:0], m2_ff[2*FB-1 -: 2]} | {rem_ff, 2'b00};
   assign sqrt_trial = {1'b0, root_ff, 2'b01};
   assign sqrt_ge    = (sqrt_sh >= sqrt_trial);
   assign sqrt_diff  = sqrt_sh - sqrt_trial;

   assign div_sh   = {rem_ff[FB-1:0], dvd_ff[FB-2]};
   assign div_ge   = (div_sh >= {1'b0, root_ff});
   assign div_diff = div_sh - {1'b0, root_ff};
   assign q_next   = {dvd_ff[FB-3:0], div_ge};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid && !ext_ff) state_in = ST_SCALE_MUL;
         ST_SCALE_MUL: state_in = ST_SCALE_RND;
         ST_SCALE_RND: begin
            if (!last_idx)      state_in = ST_SCALE_MUL;
            else if (primed_ff) state_in = ST_FILT_MUL;
            else if (near_ff)   state_in = ST_DONE;
            else                state_in = ST_SQ_MUL;
         end
         ST_FILT_MUL:  state_in = ST_FILT_ADD;
         ST_FILT_ADD: begin
            if (!last_idx)    state_in = ST_FILT_MUL;
            else if (near_ff) state_in = ST_DONE;
            else              state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL:    state_in = ST_SQ_ACC;
         ST_SQ_ACC:    state_in = last_idx ? ST_LIM_MUL : ST_SQ_MUL;
         ST_LIM_MUL:   state_in = ST_CMP;
         ST_CMP:       state_in = over_limit ? ST_SQRT : ST_DONE;
         ST_SQRT:      if (sqrt_last) state_in = ST_DIV_MUL;
         ST_DIV_MUL:   state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV_ITER;
         ST_DIV_ITER:  if (div_last) state_in = last_idx ? ST_DONE : ST_DIV_MUL;
         ST_DONE:      if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      vec_in       = vec_ff;
      filt_in      = filt_ff;
      near_in      = near_ff;
      primed_in    = primed_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      m2_in        = m2_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               near_in = req_near_switch;
               idx_in  = 2'd0;
               m2_in   = '0;
            end
         end
         ST_SCALE_MUL, ST_FILT_MUL, ST_SQ_MUL, ST_LIM_MUL, ST_DIV_MUL: begin
            prod_in = mul_prod;
         end
         ST_SCALE_RND: begin
            vec_in[idx_ff] = (idx_ff == 2'd1) ? -rnd_q : rnd_q;
            if (!primed_ff) filt_in[idx_ff] = (idx_ff == 2'd1) ? -rnd_q : rnd_q;
            if (last_idx) primed_in = 1'b1;
            idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
         end
         ST_FILT_ADD: begin
            filt_in[idx_ff] = filt_ff[idx_ff] + rnd_q;
            vec_in[idx_ff]  = filt_ff[idx_ff] + rnd_q;
            idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
         end
         ST_SQ_ACC: begin
            m2_in  = m2_ff + prod_ff[2*FB-1:0];
            idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
         end
         ST_CMP: begin
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         ST_SQRT: begin
            rem_in  = sqrt_ge ? sqrt_diff[FB:0] : sqrt_sh[FB:0];
            root_in = {root_ff[FB-2:0], sqrt_ge};
            m2_in   = m2_ff << 2;
            cnt_in  = cnt_ff + CNT_BITS'(1);
         end
         ST_DIV_LOAD: begin
            rem_in = {1'b0, prod_ff[2*FB-2:FB-1]};
            dvd_in = prod_ff[FB-2:0];
            cnt_in = '0;
         end
         ST_DIV_ITER: begin
            rem_in = {1'b0, div_ge ? div_diff[FB-1:0] : div_sh[FB-1:0]};
            dvd_in = q_next;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (div_last) begin
               vec_in[idx_ff] = vec_ff[idx_ff][FB-1] ? -$signed({1'b0, q_next})
                                                     : $signed({1'b0, q_next});
               idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = near_ff ? '0 : vec_ff[0];
               rsp_y_in     = near_ff ? '0 : vec_ff[1];
               rsp_z_in     = near_ff ? '0 : vec_ff[2];
            end
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         filt_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         gain_ff      <= FORCE_GAIN_RESET;
         alpha_ff     <= FILTER_ALPHA_RESET;
         maxf_ff      <= (FB-1)'(MAX_FORCE_RESET);
         ext_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_FORCE_GAIN:    gain_ff  <= csr_wdata[GAIN_BITS-1:0];
               REG_FILTER_ALPHA:  alpha_ff <= csr_wdata[GAIN_BITS-1:0];
               REG_MAX_FORCE:     maxf_ff  <= csr_wdata[FB-2:0];
               REG_EXTERNAL_MODE: ext_ff   <= csr_wdata[0];
               default:           ext_ff   <= ext_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff[0] <= req_ext_force_y;
         src_ff[1] <= req_ext_force_z;
         src_ff[2] <= req_ext_force_x;
      end
      vec_ff   <= vec_in;
      near_ff  <= near_in;
      prod_ff  <= prod_in;
      m2_ff    <= m2_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_device_force_x = rsp_x_ff;
   assign rsp_device_force_y = rsp_y_ff;
   assign rsp_device_force_z = rsp_z_ff;

   a_ext_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && ext_ff) |=> (state_ff == ST_IDLE && $stable(primed_ff)))
      else $error("item taken in external source mode started work");

   a_mag_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_MUL) |-> (root_ff != '0))
      else $error("limit divide with zero magnitude");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_ITER) |-> (rem_ff < {1'b0, root_ff}))
      else $error("divide remainder not below magnitude");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done state");

   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (cnt_ff <= CNT_BITS'(FB - 1)))
      else $error("square root ran past its digit count");

endmodule

`default_nettype wire
